// ===== src/hist_eq_pkg.sv =====
// Package with shared constants and types for the gray histogram equalizer.
`default_nettype none

package hist_eq_pkg;

	// Histogram geometry
	localparam int LEVELS  = 256;
	localparam int LVL_W   = 8;
	localparam int BIN_W   = 23;
	localparam int CUM_W   = BIN_W + LVL_W;
	localparam int NUM_W   = CUM_W + 8;
	localparam int QUO_W   = 9;
	localparam int STEP_W  = 4;
	localparam int PIXEL_LIMIT = 4194304;

	localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

	// Q16 luma coefficients and rounding offset
	localparam int SUM_W = 24;
	localparam logic [SUM_W-1:0] COEF_R      = 24'd19595;
	localparam logic [SUM_W-1:0] COEF_G      = 24'd38470;
	localparam logic [SUM_W-1:0] COEF_B      = 24'd7471;
	localparam logic [SUM_W-1:0] COEF_OFFSET = 24'd6554;

	// Function codes carried in tuser
	typedef enum logic [1:0] {
		F_COUNT = 2'd0,
		F_BUILD = 2'd1,
		F_MAP   = 2'd2,
		F_CLEAR = 2'd3
	} func_t;

	// Build sequencer states
	typedef enum logic [5:0] {
		ST_RUN = 6'b000001,
		ST_RD  = 6'b000010,
		ST_ACC = 6'b000100,
		ST_NUM = 6'b001000,
		ST_DIV = 6'b010000,
		ST_WR  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== src/histogram_equalizer_gray.sv =====
// Gray histogram equalizer: counts gray levels, builds the equalization map, maps pixels.
//
// Input stream (s_*): each transaction carries one RGB pixel in s_tdata and a
// function code in s_tuser: count the pixel, build the map, map the pixel, or
// clear the histogram. Output stream (m_*): one transaction per map item with
// the equalized gray level. cfg_we/cfg_data write the frame pixel count,
// saturated to the pixel limit; write it only while the block is idle.
// Count, map and clear items are accepted one per cycle while no build runs
// and the pipeline does not hold. A map result passes stages s1, s2 and s3
// and the output register before it shows on m_tvalid. The histogram and the
// map live in two 256-entry memories with registered reads; counts run a
// read-modify-write through stages s2 and s3 with forwarding of the last write.
// A build item closes the input until the map is done: a sequencer walks the
// 256 levels, each by read, accumulate, scale, 9-step restoring divide and write.
// Reset clears the histogram at once through per-bin valid bits; the map is
// undefined until the first build. When m_tready is low and a map result
// waits, counts keep flowing; the pipeline holds only when another map
// result reaches the last stage.
`default_nettype none

module histogram_equalizer_gray (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Frame pixel count
	input  wire logic                          cfg_we,
	input  wire logic [hist_eq_pkg::BIN_W-1:0] cfg_data,
	// Pixel input
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [23:0]                   s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  wire logic [1:0]                    s_tuser,   // func[1:0]
	// Equalized gray output
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata    // gray_out[7:0]
);

	import hist_eq_pkg::*;

	localparam logic [SUM_W:0] LIMIT = (SUM_W+1)'(PIXEL_LIMIT);

	// Storage
	logic [BIN_W-1:0] hist_mem [LEVELS];
	logic [7:0]       map_mem  [LEVELS];
	logic [LEVELS-1:0] hist_vld_q;

	// Control and configuration
	state_t            st_q;
	logic [BIN_W-1:0]  pc_q;
	logic              adv;
	logic              accept;
	logic              bld_busy;

	// Pipeline stages
	logic              v_s1, v_s2, v_s3;
	func_t             func_s1, func_s2, func_s3;
	logic [7:0]        red_s1, green_s1, blue_s1;
	logic [SUM_W-1:0]  pr_s2, pg_s2, pb_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [LVL_W-1:0]  gray_s2, gray_s3;
	logic [BIN_W-1:0]  hrd_s3;
	logic              hvld_s3;
	logic [7:0]        mrd_s3;

	// Read-modify-write path
	logic [LVL_W-1:0]  hist_raddr;
	logic              hist_we;
	logic [BIN_W-1:0]  bin_base;
	logic [BIN_W-1:0]  hist_wdata;
	logic              clr_s3;
	logic              wr_last_q;
	logic [LVL_W-1:0]  wr_addr_q;
	logic [BIN_W-1:0]  wr_data_q;
	logic              clr_last_q;

	// Build sequencer
	logic [LVL_W-1:0]  lvl_q;
	logic [CUM_W-1:0]  cum_q;
	logic [NUM_W-1:0]  num_q;
	logic [CUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              div_ge;

	// Output register
	logic              out_vld_q;
	logic [7:0]        out_data_q;

	// Hold the pipeline only when a map result cannot enter the output register
	assign adv      = !(v_s3 && (func_s3 == F_MAP) && out_vld_q && !m_tready);
	assign bld_busy = (v_s1 && (func_s1 == F_BUILD)) || (v_s2 && (func_s2 == F_BUILD)) ||
	                  (v_s3 && (func_s3 == F_BUILD));
	assign s_tready = adv && (st_q == ST_RUN) && !bld_busy;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Store the frame pixel count, saturated to the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= BIN_W'(1);
		end else if (cfg_we) begin
			if ({1'b0, cfg_data} > LIMIT[BIN_W:0]) begin
				pc_q <= LIMIT[BIN_W-1:0];
			end else begin
				pc_q <= cfg_data;
			end
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads: capture pixel, form products, pass gray level
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= func_t'(s_tuser);
			red_s1   <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			blue_s1  <= s_tdata[23:16];
			func_s2  <= func_s1;
			pr_s2    <= COEF_R * {16'b0, red_s1};
			pg_s2    <= COEF_G * {16'b0, green_s1};
			pb_s2    <= COEF_B * {16'b0, blue_s1};
			func_s3  <= func_s2;
			gray_s3  <= gray_s2;
		end
	end

	assign sum_s2  = pr_s2 + pg_s2 + pb_s2 + COEF_OFFSET;
	assign gray_s2 = sum_s2[SUM_W-1:SUM_W-8];

	// Histogram read address: sequencer owns the port in its read state during a build
	assign hist_raddr = (st_q == ST_RD) ? lvl_q : gray_s2;

	// Memory reads, registered
	always_ff @(posedge clk) begin
		if (adv) begin
			hrd_s3  <= hist_mem[hist_raddr];
			hvld_s3 <= hist_vld_q[hist_raddr];
			mrd_s3  <= map_mem[gray_s2];
		end
	end

	// Pick the current bin value: cleared, forwarded, or read
	always_comb begin
		if (clr_last_q) begin
			bin_base = '0;
		end else if (wr_last_q && (wr_addr_q == gray_s3)) begin
			bin_base = wr_data_q;
		end else if (hvld_s3) begin
			bin_base = hrd_s3;
		end else begin
			bin_base = '0;
		end
	end

	assign hist_wdata = (bin_base == BIN_MAX) ? bin_base : bin_base + BIN_W'(1);
	assign hist_we    = adv && v_s3 && (func_s3 == F_COUNT);
	assign clr_s3     = adv && v_s3 && (func_s3 == F_CLEAR);

	// Write back the counted bin
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[gray_s3] <= hist_wdata;
		end
	end

	// Track bin validity; clear empties the whole histogram at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (clr_s3) begin
			hist_vld_q <= '0;
		end else if (hist_we) begin
			hist_vld_q[gray_s3] <= 1'b1;
		end
	end

	// Remember the last write and clear for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_last_q  <= 1'b0;
			clr_last_q <= 1'b0;
		end else if (adv) begin
			wr_last_q  <= hist_we;
			clr_last_q <= clr_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			wr_addr_q <= gray_s3;
			wr_data_q <= hist_wdata;
		end
	end

	// Hold a map result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (adv && v_s3 && (func_s3 == F_MAP)) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && (func_s3 == F_MAP)) begin
			out_data_q <= mrd_s3;
		end
	end

	// Build sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
		end else begin
			case (st_q)
				ST_RUN: begin
					if (adv && v_s3 && (func_s3 == F_BUILD)) begin
						st_q <= ST_RD;
					end
				end
				ST_RD:  st_q <= ST_ACC;
				ST_ACC: st_q <= ST_NUM;
				ST_NUM: st_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == '0) begin
						st_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (lvl_q == LVL_W'(LEVELS - 1)) begin
						st_q <= ST_RUN;
					end else begin
						st_q <= ST_RD;
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	assign div_ge = num_q >= {{(NUM_W-CUM_W){1'b0}}, dsh_q};

	// Accumulate, scale by 255 and divide one quotient bit per cycle
	always_ff @(posedge clk) begin
		case (st_q)
			ST_RUN: begin
				lvl_q <= '0;
				cum_q <= '0;
			end
			ST_ACC: begin
				cum_q <= cum_q + (hvld_s3 ? {{LVL_W{1'b0}}, hrd_s3} : '0);
			end
			ST_NUM: begin
				num_q  <= {cum_q, 8'b0} - {8'b0, cum_q};
				dsh_q  <= {pc_q, 8'b0};
				quo_q  <= '0;
				step_q <= STEP_W'(QUO_W - 1);
			end
			ST_DIV: begin
				if (div_ge) begin
					num_q <= num_q - {{(NUM_W-CUM_W){1'b0}}, dsh_q};
				end
				quo_q  <= {quo_q[QUO_W-2:0], div_ge};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - STEP_W'(1);
			end
			ST_WR: begin
				lvl_q <= lvl_q + LVL_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Write the clamped level into the map
	always_ff @(posedge clk) begin
		if (st_q == ST_WR) begin
			map_mem[lvl_q] <= quo_q[QUO_W-1] ? 8'hFF : quo_q[7:0];
		end
	end

	// A build in flight or in progress keeps the input closed
	a_build_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(bld_busy || (st_q != ST_RUN)) |-> !s_tready)
		else $error("input accepted during a build");

	// Histogram writes come only from the count path while not building
	a_write_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> (st_q == ST_RUN))
		else $error("histogram written during a build");

	// Back-to-back counts of one bin see the previous write
	a_forward_count: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_we && $past(hist_we) && (gray_s3 == $past(gray_s3)) &&
		 ($past(hist_wdata) != BIN_MAX) && !$past(clr_s3))
		|-> (hist_wdata == $past(hist_wdata) + BIN_W'(1)))
		else $error("forwarded bin count lost");

	// The last level of a build returns the block to streaming
	a_build_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_WR) && (lvl_q == LVL_W'(LEVELS - 1))) |=> (st_q == ST_RUN))
		else $error("build did not finish after the last level");

	// Divider step count stays below the quotient width
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (step_q <= STEP_W'(QUO_W - 1)))
		else $error("divider step out of range");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the gray histogram equalizer: directed and random pixel streams.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hist_eq_pkg::*;

	// Cycles with no transaction before the run is abandoned
	localparam int WATCHDOG_LIMIT = 20000;
	// Cycles a build may still run after its last visible transaction
	localparam int BUILD_DRAIN = 3400;
	// Length of the long receiver hold-off
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [BIN_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;  // red[7:0], green[15:8], blue[23:16]
	logic [1:0] s_tuser = '0;   // func[1:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;        // gray_out[7:0]

	// Predicted block state
	logic [BIN_W-1:0] bin_count [LEVELS];
	logic [7:0] level_table [LEVELS];
	logic [BIN_W-1:0] frame_pixels = 23'd1;

	// Equalized levels still to come out, oldest first
	logic [7:0] expected_levels [$];

	int error_count = 0;
	int items_sent = 0;
	int stalled_cycles = 0;
	bit gaps_on = 1'b1;
	bit offering = 1'b0;
	bit hold_off_req = 1'b0;

	histogram_equalizer_gray dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < LEVELS; i++) begin
			bin_count[i] = '0;
			level_table[i] = '0;
		end
	end

	// Luma in Q16 with rounding offset, floored to 8 bits
	function automatic logic [7:0] luma_of(input logic [23:0] rgb);
		logic [31:0] acc;
		acc = 32'(COEF_R) * 32'(rgb[7:0]) + 32'(COEF_G) * 32'(rgb[15:8]) +
		      32'(COEF_B) * 32'(rgb[23:16]) + 32'(COEF_OFFSET);
		return acc[23:16];
	endfunction

	// Rebuild the equalization table from the cumulative histogram
	task automatic build_level_table();
		logic [63:0] running;
		logic [63:0] scaled;
		running = '0;
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			running += 64'(bin_count[lvl]);
			if (frame_pixels == 0)
				scaled = 64'd255;
			else
				scaled = (running * 64'd255) / 64'(frame_pixels);
			if (scaled > 64'd255)
				scaled = 64'd255;
			level_table[lvl] = scaled[7:0];
		end
	endtask

	// Advance the predicted state by one accepted item
	task automatic apply_item(input func_t f, input logic [23:0] rgb);
		logic [7:0] lvl;
		lvl = luma_of(rgb);
		case (f)
			F_COUNT: begin
				if (bin_count[lvl] != BIN_MAX)
					bin_count[lvl] = bin_count[lvl] + BIN_W'(1);
			end
			F_BUILD: build_level_table();
			F_MAP: expected_levels.push_back(level_table[lvl]);
			default: begin
				for (int i = 0; i < LEVELS; i++)
					bin_count[i] = '0;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		error_count++;
	endtask

	// Offer one item, hold it until the transaction, then predict
	task automatic send_item(input func_t f, input logic [23:0] rgb);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			if (offering)
				s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rgb;
		s_tuser <= f;
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		apply_item(f, rgb);
	endtask

	// Drop valid and let a clock edge pass when an item was on offer
	task automatic quiet_sender();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_results();
		quiet_sender();
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	// Write the frame pixel count once the block is idle
	task automatic set_pixel_count(input int value);
		wait_results();
		repeat (BUILD_DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= BIN_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_pixels = (value > PIXEL_LIMIT) ? BIN_W'(PIXEL_LIMIT) : BIN_W'(value);
	endtask

	function automatic logic [23:0] random_pixel();
		logic [7:0] v;
		v = 8'($urandom);
		case ($urandom_range(0, 3))
			0: return {v, v, v};
			1: return {{8{v[2]}}, {8{v[1]}}, {8{v[0]}}};
			default: return 24'($urandom);
		endcase
	endfunction

	// Empty histogram after reset: every level maps to zero
	task automatic test_empty_table();
		send_item(F_BUILD, 24'h000000);
		send_item(F_MAP, 24'h000000);
		send_item(F_MAP, 24'hFFFFFF);
		wait_results();
	endtask

	// Six pixels: the gray extremes, mid gray and the three primaries
	task automatic test_small_frame();
		set_pixel_count(6);
		send_item(F_CLEAR, 24'h000000);
		send_item(F_COUNT, 24'h000000);
		send_item(F_COUNT, 24'hFFFFFF);
		send_item(F_COUNT, 24'h0000FF);
		send_item(F_COUNT, 24'h00FF00);
		send_item(F_COUNT, 24'hFF0000);
		send_item(F_COUNT, 24'h808080);
		send_item(F_BUILD, 24'h123456);
		send_item(F_MAP, 24'h000000);
		send_item(F_MAP, 24'hFFFFFF);
		send_item(F_MAP, 24'h808080);
		send_item(F_MAP, 24'h00FF00);
		wait_results();
	endtask

	// A zero pixel count maps every level to full scale
	task automatic test_zero_pixel_count();
		set_pixel_count(0);
		send_item(F_BUILD, 24'h000000);
		send_item(F_MAP, 24'h0000FF);
		wait_results();
	endtask

	// Largest legal count, then a write above the limit that saturates
	task automatic test_pixel_count_limit();
		set_pixel_count(PIXEL_LIMIT);
		send_item(F_BUILD, 24'h000000);
		send_item(F_MAP, 24'hFFFFFF);
		set_pixel_count(int'(BIN_MAX));
		send_item(F_BUILD, 24'h000000);
		send_item(F_MAP, 24'hFFFFFF);
		wait_results();
	endtask

	// Clear empties the histogram but keeps the table
	task automatic test_clear_keeps_table();
		set_pixel_count(1);
		send_item(F_BUILD, 24'h000000);
		send_item(F_CLEAR, 24'h000000);
		send_item(F_MAP, 24'h808080);
		send_item(F_BUILD, 24'h000000);
		send_item(F_MAP, 24'h808080);
		wait_results();
	endtask

	// Long receiver hold-off while the sender keeps offering
	task automatic test_output_hold_off();
		hold_off_req = 1'b1;
		repeat (80)
			send_item(($urandom_range(0, 3) == 0) ? F_COUNT : F_MAP, random_pixel());
		wait_results();
	endtask

	// Frames of clear, counts, build and maps, with some noise and broken frames
	task automatic run_random_frames(input int target);
		int start;
		int pixels;
		int maps;
		int mode;
		start = items_sent;
		while (items_sent - start < target) begin
			pixels = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 60);
			maps = $urandom_range(1, 30);
			if ($urandom_range(0, 1) == 0) begin
				mode = $urandom_range(0, 9);
				if (mode < 6)
					set_pixel_count(pixels);
				else if (mode == 6)
					set_pixel_count(0);
				else if (mode == 7)
					set_pixel_count(int'(BIN_MAX));
				else if (mode == 8)
					set_pixel_count($urandom_range(1, PIXEL_LIMIT));
				else
					set_pixel_count($urandom_range(1, 2 * pixels));
			end
			// Skip the clear now and then so the histogram carries over
			if ($urandom_range(0, 7) != 0)
				send_item(F_CLEAR, random_pixel());
			repeat (pixels) begin
				if ($urandom_range(0, 29) == 0)
					send_item(($urandom_range(0, 1) == 0) ? F_MAP : F_CLEAR, random_pixel());
				send_item(F_COUNT, random_pixel());
			end
			send_item(F_BUILD, random_pixel());
			repeat (maps)
				send_item(F_MAP, random_pixel());
		end
		wait_results();
	endtask

	// Receiver: random stalls, and the long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Compare each output transaction with the oldest expected level
	always @(posedge clk) begin : check_results
		logic [7:0] exp_level;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				report_mismatch("gray_out with nothing expected", -1, int'(m_tdata));
			end else begin
				exp_level = expected_levels.pop_front();
				if (m_tdata !== exp_level)
					report_mismatch("gray_out", int'(exp_level), int'(m_tdata));
			end
		end
	end

	// Abandon the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_small_frame();
		test_zero_pixel_count();
		test_pixel_count_limit();
		test_clear_keeps_table();
		test_output_hold_off();
		run_random_frames(1300);

		// Final stretch with no idling on either side
		gaps_on = 1'b0;
		run_random_frames(150);

		wait_results();
		repeat (BUILD_DRAIN) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
